// ===== hdl/signed_integer_to_radix_text_defines.svh =====
// Assertion macros shared by the radix text block.
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SIRT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sirt assertion failed");

// Next-cycle implication, disabled during reset.
`define SIRT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sirt assertion failed");

`endif

// ===== hdl/sirt_pkg.sv =====
// Shared types, constants and helpers of the radix text block.
`default_nettype none
package sirt_pkg;

    localparam int MAX_RADIX_DEF = 16;
    localparam int MAX_DIGITS    = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int NUM_W         = 32;
    localparam int RADIX_W       = 5;
    localparam int ALPHA_CHARS   = 16;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_NUL   = 8'd0;

    typedef enum logic [1:0] {
        REG_DIGITS_LOW   = 2'd0,
        REG_DIGITS_HIGH  = 2'd1,
        REG_RADIX_LENGTH = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [8*ALPHA_CHARS-1:0] alpha;  // {digits_high, digits_low}
        logic [RADIX_W-1:0]       radix;
    } cfg_t;

    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] mag;
    } item_t;

    function automatic logic [7:0] alpha_char(input logic [8*ALPHA_CHARS-1:0] alpha,
                                              input logic [3:0] idx);
        return alpha[{idx, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/signed_integer_to_radix_text.sv =====
// Top level of the signed integer to radix text block: configuration registers and wiring.
//
// Usage:
//   s_t* channel takes one signed 32-bit number per item (s_tdata[31:0]).
//   m_t* channel gives one character per item in m_tdata[7:0]; m_tlast marks
//   the last character of a number. A negative number starts with '-'.
//   cfg_we/cfg_index/cfg_wdata write digits_low (0), digits_high (1) and
//   radix_length (2); write only while no number is in flight.
//   Accepted numbers pass a two-entry queue, so the input keeps accepting
//   while the back end converts, until the queue is full. Numbers seen with
//   an invalid alphabet are consumed and print nothing.
//   Per number, the divider makes 8 quotient bits per cycle, one digit per
//   full 32-bit division; then the sign, if any, and the digits go out as
//   one character per cycle while m_tready does not stall them.
//   Radix 16 needs up to 8 digits, radix 2 up to 32.
//   A stalled m_tready holds the current character and the character output waits.
//   Reset clears the registers (alphabet invalid) and empties the queue.
`default_nettype none
module signed_integer_to_radix_text
    import sirt_pkg::*;
#(
    parameter int MAX_RADIX = MAX_RADIX_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [NUM_W-1:0] s_tdata,    // [31:0] number
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,    // [7:0] text_char
    output logic                  m_tlast,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [63:0]      cfg_wdata
);
    logic [63:0]        digits_low_reg, digits_high_reg;
    logic [RADIX_W-1:0] radix_reg;
    cfg_t               cfg;
    logic               push, full, pop, not_empty;
    item_t              push_item, pop_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_low_reg  <= '0;
            digits_high_reg <= '0;
            radix_reg       <= '0;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_DIGITS_LOW:   digits_low_reg  <= cfg_wdata;
                REG_DIGITS_HIGH:  digits_high_reg <= cfg_wdata;
                REG_RADIX_LENGTH: radix_reg       <= cfg_wdata[RADIX_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.alpha = {digits_high_reg, digits_low_reg};
    assign cfg.radix = radix_reg;

    sirt_front #(.MAX_RADIX(MAX_RADIX)) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg        (cfg),
        .queue_full (full),
        .push       (push),
        .push_item  (push_item)
    );

    sirt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (not_empty)
    );

    sirt_back #(.MAX_RADIX(MAX_RADIX)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (not_empty),
        .q_item   (pop_item),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ===== hdl/sirt_queue.sv =====
// Short item queue between the front and back parts.
`default_nettype none
module sirt_queue
    import sirt_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output item_t      pop_item,
    output logic       not_empty
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sirt_front.sv =====
// Front part: accepts numbers, checks the alphabet and splits sign from magnitude.
`default_nettype none
module sirt_front
    import sirt_pkg::*;
#(
    parameter int MAX_RADIX = MAX_RADIX_DEF
) (
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [NUM_W-1:0] s_tdata,   // [31:0] number
    input  wire cfg_t             cfg,
    input  wire logic             queue_full,
    output logic                  push,
    output item_t                 push_item
);
    logic       alpha_ok;
    logic [7:0] ci;

    // Alphabet check: radix range, illegal characters and all character pairs in use
    always_comb begin
        alpha_ok = (cfg.radix >= RADIX_W'(2)) && (cfg.radix <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < ALPHA_CHARS; i++) begin
            ci = alpha_char(cfg.alpha, 4'(i));
            if (RADIX_W'(i) < cfg.radix) begin
                if (ci == CHAR_NUL || ci == CHAR_PLUS || ci == CHAR_MINUS ||
                    ci == CHAR_SPACE || (ci >= CHAR_TAB && ci <= CHAR_CR)) begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < ALPHA_CHARS; j++) begin
                    if (RADIX_W'(j) < cfg.radix && alpha_char(cfg.alpha, 4'(j)) == ci) begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign s_tready = !queue_full;
    // drop items outright when the alphabet is bad: they print nothing
    assign push          = s_tvalid && s_tready && alpha_ok;
    assign push_item.neg = s_tdata[NUM_W-1];
    assign push_item.mag = s_tdata[NUM_W-1] ? (~s_tdata + 1'b1) : s_tdata;

endmodule
`default_nettype wire

// ===== hdl/sirt_back.sv =====
// Back part: digit extraction by iterative division, digit stack and character output.
`default_nettype none
`include "signed_integer_to_radix_text_defines.svh"
module sirt_back
    import sirt_pkg::*;
#(
    parameter int MAX_RADIX = MAX_RADIX_DEF
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  q_valid,
    input  wire item_t q_item,
    output logic       q_pop,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output logic [7:0] m_tdata,   // [7:0] text_char
    output logic       m_tlast
);
    localparam int DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int ND_W    = $clog2(MAX_DIGITS + 1);
    localparam int BITS_PER_CYCLE = 8;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SIGN = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [NUM_W-1:0]         quo_reg, quo_next;
    logic [3:0]               rem_reg, rem_next;
    logic [1:0]               step_reg, step_next;
    logic                     neg_reg, neg_next;
    logic [ND_W-1:0]          nd_reg, nd_next;
    logic [DIGIT_W-1:0]       stack_reg [MAX_DIGITS];
    logic [DIGIT_W-1:0]       stack_next [MAX_DIGITS];
    logic                     m_valid_reg, m_valid_next;
    logic [7:0]               m_data_reg, m_data_next;
    logic                     m_last_reg, m_last_next;

    logic [NUM_W-1:0]         div_q;
    logic [3:0]               div_r;
    logic [4:0]               r5;
    logic                     ge;
    logic                     slot_free;

    // Eight restoring division steps per cycle
    always_comb begin
        div_q = quo_reg;
        div_r = rem_reg;
        r5    = '0;
        ge    = 1'b0;
        for (int k = 0; k < BITS_PER_CYCLE; k++) begin
            r5    = {div_r, div_q[NUM_W-1]};
            ge    = (r5 >= cfg.radix);
            div_q = {div_q[NUM_W-2:0], ge};
            if (ge) begin
                r5 = r5 - cfg.radix;
            end
            div_r = r5[3:0];
        end
    end

    assign slot_free = !m_valid_reg || m_tready;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;

    always_comb begin
        state_next   = state_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        neg_next     = neg_reg;
        nd_next      = nd_reg;
        stack_next   = stack_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    quo_next   = q_item.mag;
                    neg_next   = q_item.neg;
                    rem_next   = '0;
                    step_next  = '0;
                    nd_next    = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                quo_next  = div_q;
                rem_next  = div_r;
                step_next = step_reg + 1'b1;
                if (step_reg == 2'd3) begin
                    // push the finished digit and restart on the quotient
                    for (int k = 1; k < MAX_DIGITS; k++) begin
                        stack_next[k] = stack_reg[k-1];
                    end
                    stack_next[0] = div_r[DIGIT_W-1:0];
                    nd_next       = nd_reg + 1'b1;
                    rem_next      = '0;
                    if (div_q == '0) begin
                        state_next = neg_reg ? S_SIGN : S_EMIT;
                    end
                end
            end
            S_SIGN: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = CHAR_MINUS;
                    m_last_next  = 1'b0;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = alpha_char(cfg.alpha, 4'(stack_reg[0]));
                    m_last_next  = (nd_reg == ND_W'(1));
                    // pop the top digit
                    for (int k = 0; k < MAX_DIGITS - 1; k++) begin
                        stack_next[k] = stack_reg[k+1];
                    end
                    nd_next = nd_reg - 1'b1;
                    if (nd_reg == ND_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        neg_reg    <= neg_next;
        nd_reg     <= nd_next;
        stack_reg  <= stack_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `SIRT_ASSERT_NEXT(a_pop_starts_div, aclk, aresetn, q_pop, state_reg == S_DIV)
    `SIRT_ASSERT_NOW(a_emit_has_digit, aclk, aresetn, state_reg == S_EMIT, nd_reg != '0)
    `SIRT_ASSERT_NOW(a_div_fits_stack, aclk, aresetn, state_reg == S_DIV, nd_reg < ND_W'(MAX_DIGITS))
    `SIRT_ASSERT_NOW(a_no_pop_while_busy, aclk, aresetn, state_reg != S_IDLE, !q_pop)

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for signed_integer_to_radix_text: alphabets and numbers checked against a text predictor.
`timescale 1ns / 100ps

module tb;
    import sirt_pkg::*;

    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 300;

    localparam logic [127:0] HEX_DIGITS = {64'h4645_4443_4241_3938, 64'h3736_3534_3332_3130};
    // decimal alphabet with a '-' and zero bytes past its length, which must not matter
    localparam logic [127:0] DEC_DIGITS = {64'h0000_0000_002D_3938, 64'h3736_3534_3332_3130};
    localparam logic [127:0] BIN_DIGITS = {64'h0, 64'h0000_0000_0000_3130};

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } text_char_t;

    class radix_text_tracker;
        logic [8*ALPHA_CHARS-1:0] alphabet;
        logic [RADIX_W-1:0]       radix;
        text_char_t               pending_chars[$];
        int                       mismatches;
        int                       chars_checked;
        int                       numbers_seen;
        int                       numbers_printed;

        function new();
            alphabet        = '0;
            radix           = '0;
            mismatches      = 0;
            chars_checked   = 0;
            numbers_seen    = 0;
            numbers_printed = 0;
        endfunction

        static function bit char_legal(logic [7:0] c);
            return !(c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_SPACE ||
                     (c >= CHAR_TAB && c <= CHAR_CR));
        endfunction

        function void write_reg(reg_index_t idx, logic [63:0] v);
            case (idx)
                REG_DIGITS_LOW:   alphabet[63:0]   = v;
                REG_DIGITS_HIGH:  alphabet[127:64] = v;
                REG_RADIX_LENGTH: radix            = v[RADIX_W-1:0];
                default: ;
            endcase
        endfunction

        function bit alphabet_valid();
            int i;
            int j;
            if (radix < 2 || radix > MAX_RADIX_DEF)
                return 1'b0;
            for (i = 0; i < radix; i++) begin
                if (!char_legal(alphabet[8*i +: 8]))
                    return 1'b0;
                for (j = i + 1; j < radix; j++)
                    if (alphabet[8*j +: 8] == alphabet[8*i +: 8])
                        return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_number(logic [NUM_W-1:0] raw);
            logic [NUM_W-1:0] mag;
            logic [7:0]       digs[MAX_DIGITS];
            int               nd;
            int               i;
            numbers_seen++;
            if (!alphabet_valid())
                return;
            numbers_printed++;
            // unsigned negate gives 2^31 for the most negative number
            mag = raw[NUM_W-1] ? (32'd0 - raw) : raw;
            nd  = 0;
            do begin
                digs[nd] = alphabet[8*(mag % radix) +: 8];
                nd++;
                mag = mag / radix;
            end while (mag != 0);
            if (raw[NUM_W-1])
                pending_chars.push_back(text_char_t'{ch: CHAR_MINUS, is_last: 1'b0});
            for (i = nd - 1; i >= 0; i--)
                pending_chars.push_back(text_char_t'{ch: digs[i], is_last: (i == 0)});
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        function void check_char(logic [7:0] c, logic last_flag);
            text_char_t want;
            chars_checked++;
            if (pending_chars.size() == 0) begin
                flag($sformatf("unexpected character 0x%02h tlast=%b", c, last_flag));
                return;
            end
            want = pending_chars.pop_front();
            if (c !== want.ch)
                flag($sformatf("char expected 0x%02h got 0x%02h", want.ch, c));
            if (last_flag !== want.is_last)
                flag($sformatf("tlast expected %b got %b (char 0x%02h)", want.is_last,
                               last_flag, want.ch));
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [NUM_W-1:0] s_tdata;   // [31:0] number
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;   // [7:0] text_char
    logic             m_tlast;
    logic             cfg_we;
    reg_index_t       cfg_index;
    logic [63:0]      cfg_wdata;

    bit sender_idles;
    bit receiver_idles;
    bit hold_request;
    int cfg_count;

    radix_text_tracker tracker = new();

    signed_integer_to_radix_text dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d characters still expected", tracker.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end
            m_tready <= !(receiver_idles && $urandom_range(99) < 16);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_char(m_tdata, m_tlast);
    end

    task automatic send_number(logic [NUM_W-1:0] v);
        @(negedge aclk);
        while (sender_idles && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        tracker.note_number(v);
    endtask

    // drop valid, wait for every expected character, then let the block go quiet
    task automatic settle(int extra);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [63:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        tracker.write_reg(idx, v);
    endtask

    task automatic load_alphabet(logic [127:0] alpha, logic [RADIX_W-1:0] len);
        write_reg(REG_DIGITS_LOW, alpha[63:0]);
        write_reg(REG_DIGITS_HIGH, alpha[127:64]);
        write_reg(REG_RADIX_LENGTH, {59'd0, len});
        @(negedge aclk);
        cfg_we <= 1'b0;
        cfg_count++;
    endtask

    function automatic logic [127:0] with_char(logic [127:0] a, int pos, logic [7:0] c);
        a[8*pos +: 8] = c;
        return a;
    endfunction

    function automatic logic [NUM_W-1:0] random_number();
        logic [NUM_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4, 5: begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1)) v = 32'd0 - v;
            end
            6: begin
                v = $urandom_range(40);
                if ($urandom_range(1)) v = 32'd0 - v;
            end
            7: begin
                case ($urandom_range(4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h1;
                endcase
            end
            default: v = $urandom | 32'h8000_0000;
        endcase
        return v;
    endfunction

    // distinct legal characters; sometimes junk of any kind past the length
    function automatic logic [127:0] random_alphabet(int len);
        logic [127:0] a;
        logic [7:0]   c;
        bit           ok;
        int           k;
        int           j;
        a = '0;
        for (k = 0; k < ALPHA_CHARS; k++) begin
            do begin
                c  = 8'($urandom_range(255));
                ok = radix_text_tracker::char_legal(c);
                for (j = 0; j < k; j++)
                    if (a[8*j +: 8] == c) ok = 1'b0;
            end while (!ok);
            a[8*k +: 8] = c;
        end
        if ($urandom_range(3) == 0)
            for (k = len; k < ALPHA_CHARS; k++)
                a[8*k +: 8] = 8'($urandom_range(255));
        return a;
    endfunction

    // spoil a valid alphabet in one of the ways that makes it unusable
    function automatic void make_broken(inout logic [127:0] alpha,
                                        inout logic [RADIX_W-1:0] len);
        int p;
        int q;
        p = $urandom_range(len - 1);
        case ($urandom_range(6))
            0: len = RADIX_W'($urandom_range(1));
            1: len = RADIX_W'($urandom_range(17, 31));
            2: alpha = with_char(alpha, p, CHAR_PLUS);
            3: alpha = with_char(alpha, p, CHAR_MINUS);
            4: alpha = with_char(alpha, p, $urandom_range(1) ? CHAR_SPACE : CHAR_NUL);
            5: alpha = with_char(alpha, p, 8'($urandom_range(CHAR_TAB, CHAR_CR)));
            default: begin
                p = $urandom_range(1, len - 1);
                q = $urandom_range(p - 1);
                alpha = with_char(alpha, p, alpha[8*q +: 8]);
            end
        endcase
    endfunction

    task automatic probe_broken(logic [127:0] alpha, logic [RADIX_W-1:0] len, int n);
        load_alphabet(alpha, len);
        repeat (n) send_number(random_number());
        settle(SETTLE_CYCLES);
    endtask

    initial begin
        logic [NUM_W-1:0]   nums[$];
        logic [7:0]         bad_chars[$];
        logic [127:0]       alpha;
        logic [RADIX_W-1:0] len;
        int                 random_items;
        int                 phase;
        int                 n;
        int                 i;

        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_DIGITS_LOW;
        cfg_wdata      = '0;
        aresetn        = 1'b0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        hold_request   = 1'b0;
        cfg_count      = 0;
        random_items   = 0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // registers come out of reset empty: numbers are swallowed
        send_number(32'd5);
        send_number(32'h8000_0000);
        settle(SETTLE_CYCLES);

        nums = {32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd10, 32'hFFFF_FFF7};
        load_alphabet(DEC_DIGITS, 5'd10);
        foreach (nums[i]) send_number(nums[i]);
        settle(SETTLE_CYCLES);

        // hex with no idling on either side
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        nums = {32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd15, 32'd16};
        load_alphabet(HEX_DIGITS, 5'd16);
        foreach (nums[i]) send_number(nums[i]);
        settle(SETTLE_CYCLES);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;

        nums = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0};
        load_alphabet(BIN_DIGITS, 5'd2);
        foreach (nums[i]) send_number(nums[i]);
        settle(SETTLE_CYCLES);

        bad_chars = {CHAR_PLUS, CHAR_MINUS, CHAR_SPACE, CHAR_TAB, CHAR_CR, 8'd11, CHAR_NUL};
        foreach (bad_chars[i])
            probe_broken(with_char(HEX_DIGITS, $urandom_range(15), bad_chars[i]), 5'd16, 1);
        probe_broken(HEX_DIGITS, 5'd1, 1);
        probe_broken(HEX_DIGITS, 5'd17, 1);
        probe_broken(HEX_DIGITS, 5'd31, 1);
        probe_broken(with_char(HEX_DIGITS, 15, HEX_DIGITS[7:0]), 5'd16, 1);

        // long output stall while the sender keeps going: the input must back up
        load_alphabet(BIN_DIGITS, 5'd2);
        hold_request = 1'b1;
        repeat (6) send_number($urandom | 32'h8000_0000);
        settle(SETTLE_CYCLES);

        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       len = 5'd2;
                1:       len = 5'd16;
                default: len = RADIX_W'($urandom_range(2, 16));
            endcase
            alpha = random_alphabet(len);
            if ($urandom_range(6) == 0) begin
                make_broken(alpha, len);
                probe_broken(alpha, len, 3);
            end else begin
                sender_idles   = (phase != 1);
                receiver_idles = (phase != 1);
                n = $urandom_range(20, 45);
                load_alphabet(alpha, len);
                for (i = 0; i < n; i++) begin
                    send_number(random_number());
                    // hold the input until the output has caught up
                    if (phase % 3 == 0 && i == n / 2)
                        settle(0);
                end
                settle(SETTLE_CYCLES);
                random_items += n;
                phase++;
            end
        end

        $display("covered %0d numbers (%0d printed, %0d dropped by bad alphabets), %0d chars",
                 tracker.numbers_seen, tracker.numbers_printed,
                 tracker.numbers_seen - tracker.numbers_printed, tracker.chars_checked);
        $display("across %0d alphabet loads, radix 2 to 16, with stalls and a long hold-off",
                 cfg_count);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d characters never seen", tracker.mismatches,
                     tracker.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
